FILE: rtl/p2w_pkg.sv
`default_nettype none

package p2w_pkg;

  localparam int KDIM_W     = 5;
  localparam int PAD_W      = 4;
  localparam int PLANE_W    = 8;
  localparam int POS_IN_W   = 8;
  localparam int SAMPLE_W   = 16;
  localparam int CNT_W      = 2 * KDIM_W;
  localparam int SUM_W      = SAMPLE_W + CNT_W;
  localparam int PROD_W     = POS_IN_W + KDIM_W;
  localparam int POS_W      = PROD_W + 1;
  localparam int END_W      = POS_W + 1;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } p2w_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_HEIGHT = 3'd0,
    REG_KERNEL_WIDTH  = 3'd1,
    REG_STRIDE_ROWS   = 3'd2,
    REG_STRIDE_COLS   = 3'd3,
    REG_PAD_ROWS      = 3'd4,
    REG_PAD_COLS      = 3'd5,
    REG_PLANE_HEIGHT  = 3'd6,
    REG_PLANE_WIDTH   = 3'd7
  } p2w_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HSTART,
    S_CLIP,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_DIV,
    S_OUT
  } p2w_state_t;

  typedef struct packed {
    logic [KDIM_W-1:0]  kernel_height;
    logic [KDIM_W-1:0]  kernel_width;
    logic [KDIM_W-1:0]  stride_rows;
    logic [KDIM_W-1:0]  stride_cols;
    logic [PAD_W-1:0]   pad_rows;
    logic [PAD_W-1:0]   pad_cols;
    logic [PLANE_W-1:0] plane_height;
    logic [PLANE_W-1:0] plane_width;
  } p2w_cfg_t;

  localparam p2w_cfg_t CFG_RESET = '{
    kernel_height: 5'd2,
    kernel_width:  5'd2,
    stride_rows:   5'd2,
    stride_cols:   5'd2,
    pad_rows:      4'd0,
    pad_cols:      4'd0,
    plane_height:  8'd128,
    plane_width:   8'd128
  };

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] value;
    logic                       empty;
  } p2w_res_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } p2w_div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] quotient;
  } p2w_div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/p2w_if.sv
`default_nettype none

interface p2w_in_if import p2w_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [POS_IN_W-1:0]        row;
  logic [POS_IN_W-1:0]        col;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output opcode, output row, output col, output sample,
                  input ready);
  modport sink (input valid, input opcode, input row, input col, input sample,
                output ready);
endinterface

interface p2w_out_if import p2w_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] pooled_value;
  logic                       empty_window;

  modport source (output valid, output pooled_value, output empty_window, input ready);
  modport sink (input valid, input pooled_value, input empty_window, output ready);
endinterface

interface p2w_cfg_if import p2w_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/p2w_div.sv
`default_nettype none

module p2w_div import p2w_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire p2w_div_req_t req,
  output p2w_div_rsp_t      rsp
);

  logic                busy_r;
  logic                done_r;
  logic                neg_r;
  logic [SUM_W-1:0]    dq_r;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W-1:0]    div_r;
  logic [STEP_W-1:0]   step_r;

  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      diff;
  logic                fits;
  logic [CNT_W-1:0]    rem_nxt;
  logic [SUM_W-1:0]    mag;
  logic [SAMPLE_W-1:0] q_lo;

  // Restoring division on the magnitude, one quotient bit per cycle; the
  // sign is put back at the end so the result truncates toward zero.
  always_comb begin
    trial   = {rem_r, dq_r[SUM_W-1]};
    diff    = trial - {1'b0, div_r};
    fits    = (trial >= {1'b0, div_r});
    rem_nxt = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    mag     = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
    q_lo    = dq_r[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r  <= req.dividend[SUM_W-1];
      dq_r   <= mag;
      rem_r  <= '0;
      div_r  <= req.divisor;
      step_r <= STEP_W'(SUM_W - 1);
    end else if (busy_r) begin
      dq_r   <= {dq_r[SUM_W-2:0], fits};
      rem_r  <= rem_nxt;
      step_r <= step_r - STEP_W'(1);
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? $signed(-q_lo) : $signed(q_lo);

endmodule

`default_nettype wire

FILE: rtl/p2w_engine.sv
`default_nettype none

module p2w_engine import p2w_pkg::*; #(
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_KERNEL = 16,
  parameter int POOL_MODE  = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire p2w_cfg_t cfg,
  p2w_in_if.sink        in_if,
  output p2w_res_t      res,
  input  wire logic     res_ready
);

  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  p2w_state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] mem_q_r;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic                       rd_en;
  logic                       rd_vld_r;

  logic                in_accept;
  logic                in_ready;
  logic [POS_IN_W-1:0] q_row_r;
  logic [POS_IN_W-1:0] q_col_r;

  logic signed [POS_W-1:0] hs_r, ws_r;
  logic [PLANE_W-1:0]      h_r, w_r, w_first_r, h_end_r, w_end_r;

  logic signed [SUM_W-1:0]    acc_r;
  logic signed [SAMPLE_W-1:0] best_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [SAMPLE_W-1:0] res_val_r;
  logic                       res_empty_r;

  logic [KDIM_W-1:0]       klim_h, klim_w;
  logic [PLANE_W-1:0]      ph, pw;
  logic [PROD_W-1:0]       prod_h, prod_w;
  logic signed [POS_W-1:0] hs_calc, ws_calc;
  logic signed [POS_W-1:0] hs_c, ws_c;
  logic signed [END_W-1:0] he_full, we_full, he_e, we_e, ph_s, pw_s;
  logic                    win_empty;
  logic                    w_last, h_last;

  p2w_div_req_t div_req;
  p2w_div_rsp_t div_rsp;

  p2w_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_accept = in_if.valid && in_ready;
  assign wr_en     = in_accept && (p2w_op_t'(in_if.opcode) == OP_WRITE)
                     && (int'(in_if.row) < MAX_HEIGHT) && (int'(in_if.col) < MAX_WIDTH);
  assign wr_addr   = {RW'(in_if.row), CW'(in_if.col)};
  assign rd_addr   = {RW'(h_r), CW'(w_r)};

  // Window bounds: start at position times stride less padding, end clipped
  // to the plane, start clipped to zero.
  always_comb begin
    klim_h  = (int'(cfg.kernel_height) > MAX_KERNEL) ? KDIM_W'(MAX_KERNEL)
                                                      : cfg.kernel_height;
    klim_w  = (int'(cfg.kernel_width) > MAX_KERNEL) ? KDIM_W'(MAX_KERNEL)
                                                     : cfg.kernel_width;
    ph      = (int'(cfg.plane_height) > MAX_HEIGHT) ? PLANE_W'(MAX_HEIGHT)
                                                     : cfg.plane_height;
    pw      = (int'(cfg.plane_width) > MAX_WIDTH) ? PLANE_W'(MAX_WIDTH)
                                                   : cfg.plane_width;
    prod_h  = PROD_W'(q_row_r) * PROD_W'(cfg.stride_rows);
    prod_w  = PROD_W'(q_col_r) * PROD_W'(cfg.stride_cols);
    hs_calc = $signed({1'b0, prod_h}) - $signed(POS_W'(cfg.pad_rows));
    ws_calc = $signed({1'b0, prod_w}) - $signed(POS_W'(cfg.pad_cols));

    he_full = END_W'(hs_r) + $signed(END_W'(klim_h));
    we_full = END_W'(ws_r) + $signed(END_W'(klim_w));
    ph_s    = $signed(END_W'(ph));
    pw_s    = $signed(END_W'(pw));
    he_e    = (he_full < ph_s) ? he_full : ph_s;
    we_e    = (we_full < pw_s) ? we_full : pw_s;
    hs_c    = hs_r[POS_W-1] ? '0 : hs_r;
    ws_c    = ws_r[POS_W-1] ? '0 : ws_r;
    win_empty = (END_W'(hs_c) >= he_e) || (END_W'(ws_c) >= we_e);

    w_last  = (PLANE_W'(w_r + PLANE_W'(1)) == w_end_r);
    h_last  = (PLANE_W'(h_r + PLANE_W'(1)) == h_end_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && (p2w_op_t'(in_if.opcode) == OP_QUERY)) state_nxt = S_HSTART;
      end
      S_HSTART: state_nxt = S_CLIP;
      S_CLIP:   state_nxt = win_empty ? S_OUT : S_SCAN;
      S_SCAN: begin
        if (w_last && h_last) state_nxt = S_DRAIN;
      end
      S_DRAIN:  state_nxt = S_FINISH;
      S_FINISH: state_nxt = (POOL_MODE == 0) ? S_OUT : S_DIV;
      S_DIV: begin
        if (div_rsp.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state_r == S_IDLE);
    rd_en            = (state_r == S_SCAN);
    div_req.start    = (state_r == S_FINISH) && (POOL_MODE != 0);
    div_req.dividend = acc_r;
    div_req.divisor  = cnt_r;
    res.valid        = (state_r == S_OUT);
    res.value        = res_val_r;
    res.empty        = res_empty_r;
  end

  assign in_if.ready = in_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_if.sample;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          q_row_r <= in_if.row;
          q_col_r <= in_if.col;
        end
      end
      S_HSTART: begin
        hs_r <= hs_calc;
        ws_r <= ws_calc;
      end
      S_CLIP: begin
        h_r         <= PLANE_W'(hs_c);
        w_r         <= PLANE_W'(ws_c);
        w_first_r   <= PLANE_W'(ws_c);
        h_end_r     <= PLANE_W'(he_e);
        w_end_r     <= PLANE_W'(we_e);
        acc_r       <= '0;
        best_r      <= {1'b1, {(SAMPLE_W-1){1'b0}}};
        cnt_r       <= '0;
        res_val_r   <= '0;
        res_empty_r <= win_empty;
      end
      S_SCAN: begin
        if (w_last) begin
          w_r <= w_first_r;
          h_r <= PLANE_W'(h_r + PLANE_W'(1));
        end else begin
          w_r <= PLANE_W'(w_r + PLANE_W'(1));
        end
      end
      S_FINISH: begin
        if (POOL_MODE == 0) res_val_r <= best_r;
      end
      S_DIV: begin
        if (div_rsp.done) res_val_r <= div_rsp.quotient;
      end
      S_DRAIN, S_OUT: ;
      default: ;
    endcase

    // Read data arrives in the cycle after its address, so the fold trails
    // the scan and finishes in the drain state.
    if (rd_vld_r) begin
      acc_r <= acc_r + SUM_W'(mem_q_r);
      cnt_r <= cnt_r + CNT_W'(1);
      if (mem_q_r > best_r) best_r <= mem_q_r;
    end
  end

  a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (h_r < h_end_r && w_r < w_end_r && w_r >= w_first_r))
    else $error("scan address outside the clipped window");

  a_finish_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |-> (cnt_r != '0))
    else $error("non-empty window finished with no samples counted");

  a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> rd_vld_r)
    else $error("drain state without the last read word");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.empty) |-> (res.value == '0))
    else $error("empty window result carries a non-zero value");

endmodule

`default_nettype wire

FILE: rtl/pooling_2d_window_top.sv
// Max (POOL_MODE 0) or truncated average (POOL_MODE 1) pooling over one
// stored plane of signed Q8.8 samples held in a single-port-read memory. A
// write word stores a sample. A query word passes through window start,
// clipping, a scan of the clipped window, drain and finish, and in average
// mode the divider, before its result is offered. A query whose window is
// empty goes from clipping straight to the result in either mode. The memory
// read port delivers one sample per cycle, and the average uses a divider
// that produces one quotient bit per cycle. Only one word is worked on at a
// time, but a finished result waits in the output register so the next word
// can be taken while it is still unread. The configuration port is always
// ready, so registers must be written only while the block is idle.
`default_nettype none

module pooling_2d_window_top import p2w_pkg::*; #(
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_KERNEL = 16,
  parameter int POOL_MODE  = 0
) (
  input wire logic   clk,
  input wire logic   rst_n,
  p2w_in_if.sink     in_if,
  p2w_out_if.source  out_if,
  p2w_cfg_if.sink    cfg_if
);

  p2w_cfg_t cfg_r;
  p2w_res_t res;
  logic     res_ready;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_val_r;
  logic                       out_empty_r;

  p2w_engine #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL),
    .POOL_MODE  (POOL_MODE)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_if     (in_if),
    .res       (res),
    .res_ready (res_ready)
  );

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_if.valid) begin
      unique case (p2w_reg_t'(cfg_if.index))
        REG_KERNEL_HEIGHT: cfg_r.kernel_height <= cfg_if.data[KDIM_W-1:0];
        REG_KERNEL_WIDTH:  cfg_r.kernel_width  <= cfg_if.data[KDIM_W-1:0];
        REG_STRIDE_ROWS:   cfg_r.stride_rows   <= cfg_if.data[KDIM_W-1:0];
        REG_STRIDE_COLS:   cfg_r.stride_cols   <= cfg_if.data[KDIM_W-1:0];
        REG_PAD_ROWS:      cfg_r.pad_rows      <= cfg_if.data[PAD_W-1:0];
        REG_PAD_COLS:      cfg_r.pad_cols      <= cfg_if.data[PAD_W-1:0];
        REG_PLANE_HEIGHT:  cfg_r.plane_height  <= cfg_if.data[PLANE_W-1:0];
        REG_PLANE_WIDTH:   cfg_r.plane_width   <= cfg_if.data[PLANE_W-1:0];
        default: ;
      endcase
    end
  end

  // The output register frees itself in the same cycle its word is taken.
  assign res_ready = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_val_r   <= res.value;
      out_empty_r <= res.empty;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.pooled_value = out_val_r;
  assign out_if.empty_window = out_empty_r;

endmodule

`default_nettype wire
